FILE: sv/usc_pkg.sv
// Package with the shared types, constants and lead-byte decoder of the UTF-8 sanitizer.
package usc_pkg;

    // Byte sent in place of any broken or stray part of a sequence.
    localparam logic [7:0] REPLACEMENT = 8'h3F;

    // Most output bytes that one input byte can release.
    localparam int unsigned MAX_RUN = 4;

    // Output bytes released by one input byte, queued between front and back.
    typedef struct packed {
        logic [MAX_RUN-1:0][7:0] bytes;
        logic [2:0]              count;
        logic                    text_end;
    } run_t;

    // Sequence length announced by a lead byte; zero for a byte that cannot lead.
    function automatic logic [2:0] lead_length(input logic [7:0] b);
        logic [2:0] len;
        begin
            len = 3'd0;
            if (b <= 8'h7F) begin
                len = 3'd1;
            end
            else if ((b & 8'hE0) == 8'hC0) begin
                len = 3'd2;
            end
            else if ((b & 8'hF0) == 8'hE0) begin
                len = 3'd3;
            end
            else if ((b & 8'hF8) == 8'hF0) begin
                len = 3'd4;
            end
            return len;
        end
    endfunction

endpackage

FILE: sv/usc_in_if.sv
// Stream interface that carries raw text bytes into the sanitizer.
interface usc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

FILE: sv/usc_out_if.sv
// Stream interface that carries cleaned bytes out of the sanitizer.
interface usc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_run_last;
    logic       out_text_end;

    modport source (output valid, output out_byte, output out_run_last,
                    output out_text_end, input ready);
    modport sink   (input valid, input out_byte, input out_run_last,
                    input out_text_end, output ready);
endinterface

FILE: sv/usc_front.sv
// Front end: accepts input bytes, tracks the partial sequence and builds each output run.
module usc_front (
    input  logic           clk,
    input  logic           rst_n,
    usc_in_if.sink         in_ch,
    output logic           push_valid,
    input  logic           push_ready,
    output usc_pkg::run_t  push_data
);
    import usc_pkg::*;

    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [2:0] seq_len_reg;
    logic [2:0] seq_len_next;
    logic [7:0] held_reg  [0:2];
    logic [7:0] held_next [0:2];

    logic       accept;
    logic       is_cont;
    logic       consumed;
    logic [2:0] lead_len;
    logic [2:0] n;
    run_t       run;
    int         k;

    assign accept   = in_ch.valid && in_ch.ready;
    assign is_cont  = (in_ch.in_byte[7:6] == 2'b10);
    assign lead_len = lead_length(in_ch.in_byte);

    // Work out the run released by this byte and the sequence it leaves held.
    always_comb
    begin
        for (k = 0; k < MAX_RUN; k++)
        begin
            run.bytes[k] = REPLACEMENT;
        end
        for (k = 0; k < 3; k++)
        begin
            held_next[k] = held_reg[k];
        end
        n               = 3'd0;
        consumed        = 1'b0;
        held_count_next = held_count_reg;
        seq_len_next    = seq_len_reg;

        if (held_count_reg != 2'd0)
        begin
            if (is_cont)
            begin
                consumed = 1'b1;
                if (({1'b0, held_count_reg} + 3'd1) >= seq_len_reg)
                begin
                    // Sequence complete: held bytes and this one pass unchanged.
                    for (k = 0; k < 3; k++)
                    begin
                        if (2'(k) < held_count_reg)
                        begin
                            run.bytes[k] = held_reg[k];
                        end
                    end
                    run.bytes[held_count_reg] = in_ch.in_byte;
                    n               = {1'b0, held_count_reg} + 3'd1;
                    held_count_next = 2'd0;
                    seq_len_next    = 3'd0;
                end
                else
                begin
                    held_next[held_count_reg] = in_ch.in_byte;
                    held_count_next           = held_count_reg + 2'd1;
                end
            end
            else
            begin
                // Broken sequence: one replacement for every held byte.
                n               = {1'b0, held_count_reg};
                held_count_next = 2'd0;
                seq_len_next    = 3'd0;
            end
        end

        // The byte starts afresh as a lead.
        if (!consumed)
        begin
            if (lead_len == 3'd1)
            begin
                run.bytes[n[1:0]] = in_ch.in_byte;
                n = n + 3'd1;
            end
            else if (lead_len == 3'd0)
            begin
                n = n + 3'd1;
            end
            else
            begin
                held_next[0]    = in_ch.in_byte;
                held_count_next = 2'd1;
                seq_len_next    = lead_len;
            end
        end

        // A string end cuts off anything still held.
        if (in_ch.in_last && (held_count_next != 2'd0))
        begin
            n               = n + {1'b0, held_count_next};
            held_count_next = 2'd0;
            seq_len_next    = 3'd0;
        end

        run.count    = n;
        run.text_end = in_ch.in_last;
    end

    assign in_ch.ready = push_ready;
    assign push_valid  = accept && (n != 3'd0);
    assign push_data   = run;

    // Sequence control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            seq_len_reg    <= 3'd0;
        end
        else if (accept)
        begin
            held_count_reg <= held_count_next;
            seq_len_reg    <= seq_len_next;
        end
    end

    // Held bytes carry no reset; they are read only once written.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            for (int i = 0; i < 3; i++)
            begin
                held_reg[i] <= held_next[i];
            end
        end
    end

endmodule

FILE: sv/usc_fifo.sv
// Short queue of output runs that decouples the front end from the serializer.
module usc_fifo #(
    parameter int unsigned DEPTH = 2
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push_valid,
    output logic           push_ready,
    input  usc_pkg::run_t  push_data,
    output logic           pop_valid,
    input  logic           pop,
    output usc_pkg::run_t  pop_data
);
    import usc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    run_t             entry_reg [0:DEPTH-1];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != FULL_CNT);
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: sv/usc_back.sv
// Back end: sends the bytes of each queued run out one transaction at a time.
module usc_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           run_valid,
    input  usc_pkg::run_t  run_data,
    output logic           run_pop,
    usc_out_if.source      out_ch
);
    import usc_pkg::*;

    logic [1:0] idx_reg;
    logic       is_run_last;
    logic       send;

    assign is_run_last = (({1'b0, idx_reg} + 3'd1) == run_data.count);
    assign send        = out_ch.valid && out_ch.ready;
    assign run_pop     = send && is_run_last;

    assign out_ch.valid        = run_valid;
    assign out_ch.out_byte     = run_data.bytes[idx_reg];
    assign out_ch.out_run_last = is_run_last;
    assign out_ch.out_text_end = is_run_last && run_data.text_end;

    // Position within the current run.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= 2'd0;
        end
        else if (send)
        begin
            idx_reg <= is_run_last ? 2'd0 : idx_reg + 2'd1;
        end
    end

endmodule

FILE: sv/utf8_stream_sanitizer_core.sv
// Top level of the UTF-8 stream sanitizer: front end, run queue and output serializer.
//
// Use: raw text enters on in_ch, one byte per transaction, with in_last high on
// the final byte of each string. Cleaned bytes leave on out_ch. Each input byte
// releases zero to four output bytes; out_run_last marks the last of them and
// out_text_end marks the end of the cleaned string.
// Latency: when the run queue is empty, the first byte of a run is offered on
// out_ch in the cycle after the input transaction that releases it.
// Throughput: one output byte per cycle while out_ch.ready is high. An input byte
// that releases k bytes keeps the serializer busy until all k are sent; the run
// queue (QUEUE_DEPTH entries) lets input continue meanwhile, so plain text flows at
// one byte per cycle and input stalls only when a replacement or completion burst or an output stall fills the queue.
// Reset clears the held sequence, the queue and the serializer position; no
// partly received sequence survives it.
// When the receiver holds out_ch.ready low the output byte stays put, the queue
// fills and in_ch.ready then falls until space frees up.
module utf8_stream_sanitizer_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    usc_in_if.sink     in_ch,
    usc_out_if.source  out_ch
);
    import usc_pkg::*;

    logic push_valid;
    logic push_ready;
    run_t push_data;
    logic pop_valid;
    logic pop;
    run_t pop_data;

    // Classification and sequence tracking.
    usc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    // Run queue between the two halves.
    usc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop        (pop),
        .pop_data   (pop_data)
    );

    // Output serializer.
    usc_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .run_valid (pop_valid),
        .run_data  (pop_data),
        .run_pop   (pop),
        .out_ch    (out_ch)
    );

endmodule

FILE: test/testbench.sv
// Self-checking testbench for the UTF-8 stream sanitizer: scoreboard, stimulus and checks.
`timescale 1ns / 100ps

module testbench;

    import usc_pkg::*;

    // Cycles without any transaction before the run is declared hung.
    localparam int unsigned HANG_LIMIT = 2000;

    // Cycles allowed after the last expected byte for stray output to show up.
    localparam int unsigned DRAIN_CYCLES = 16;

    // Random text bytes to send after the directed strings.
    localparam int unsigned RANDOM_BYTES = 200;

    // One cleaned byte as it is expected on the output channel.
    typedef struct packed {
        logic [7:0] value;
        logic       run_last;
        logic       text_end;
    } clean_byte_t;

    // Tracks the partly received sequence and holds the cleaned bytes still to come.
    class utf8_scoreboard;
        logic [7:0]  held [3];
        logic [1:0]  held_count;
        logic [2:0]  seq_len;
        clean_byte_t run_q [$];
        clean_byte_t expected_q [$];
        int unsigned errors;

        function new();
            held_count = 2'd0;
            seq_len    = 3'd0;
            errors     = 0;
        endfunction

        // Length of the sequence that a byte opens; zero when it cannot open one.
        function logic [2:0] announced_length(logic [7:0] b);
            logic [2:0] len;
            casez (b)
                8'b0???????: len = 3'd1;
                8'b110?????: len = 3'd2;
                8'b1110????: len = 3'd3;
                8'b11110???: len = 3'd4;
                default:     len = 3'd0;
            endcase
            return len;
        endfunction

        // One input byte never releases more than four cleaned bytes.
        function void emit_byte(logic [7:0] v);
            clean_byte_t item;
            if (run_q.size() < MAX_RUN)
            begin
                item = '{v, 1'b0, 1'b0};
                run_q.insert(run_q.size(), item);
            end
        endfunction

        // Every held byte of a broken sequence turns into a replacement.
        function void release_as_replacements();
            int k;
            for (k = 0; k < held_count; k++)
            begin
                emit_byte(REPLACEMENT);
            end
            held_count = 2'd0;
            seq_len    = 3'd0;
        endfunction

        // Works out what an accepted input transaction releases.
        function void note_input(logic [7:0] b, logic last);
            bit         taken;
            int         k;
            logic [2:0] len;
            taken = 1'b0;
            run_q.delete();

            // A held sequence either grows, completes or breaks.
            if (held_count != 2'd0)
            begin
                if (b[7:6] == 2'b10)
                begin
                    taken = 1'b1;
                    if ({1'b0, held_count} + 3'd1 >= seq_len)
                    begin
                        for (k = 0; k < held_count; k++)
                        begin
                            emit_byte(held[k]);
                        end
                        emit_byte(b);
                        held_count = 2'd0;
                        seq_len    = 3'd0;
                    end
                    else
                    begin
                        held[held_count] = b;
                        held_count       = held_count + 2'd1;
                    end
                end
                else
                begin
                    release_as_replacements();
                end
            end

            // The byte was not absorbed, so it is examined as a new lead.
            if (!taken)
            begin
                len = announced_length(b);
                if (len == 3'd1)
                begin
                    emit_byte(b);
                end
                else if (len == 3'd0)
                begin
                    emit_byte(REPLACEMENT);
                end
                else
                begin
                    held[0]    = b;
                    held_count = 2'd1;
                    seq_len    = len;
                end
            end

            // Nothing stays held across the end of a string.
            if (last && held_count != 2'd0)
            begin
                release_as_replacements();
            end

            if (run_q.size() != 0)
            begin
                run_q[$].run_last = 1'b1;
                run_q[$].text_end = last;
            end
            foreach (run_q[i])
            begin
                expected_q.insert(expected_q.size(), run_q[i]);
            end
        endfunction

        // Compares an accepted output transaction with the oldest expected byte.
        function void check_result(logic [7:0] v, logic run_last, logic text_end);
            clean_byte_t exp_byte;
            if (expected_q.size() == 0)
            begin
                $error("unexpected output byte %h (run_last %b, text_end %b)",
                       v, run_last, text_end);
                errors++;
                return;
            end
            exp_byte = expected_q.pop_front();
            if (v !== exp_byte.value)
            begin
                $error("out_byte mismatch: expected %h, got %h", exp_byte.value, v);
                errors++;
            end
            if (run_last !== exp_byte.run_last)
            begin
                $error("out_run_last mismatch: expected %b, got %b",
                       exp_byte.run_last, run_last);
                errors++;
            end
            if (text_end !== exp_byte.text_end)
            begin
                $error("out_text_end mismatch: expected %b, got %b",
                       exp_byte.text_end, text_end);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    usc_in_if  in_ch ();
    usc_out_if out_ch ();

    utf8_stream_sanitizer_core dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    utf8_scoreboard sb;
    logic [7:0]     text_bytes [$];
    int unsigned    sent_bytes;
    bit             quiet;
    int unsigned    idle_cycles;

    // Free-running clock.
    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Idle spans: mostly short, now and then long, none while a quiet stretch runs.
    function automatic int unsigned pick_gap();
        int unsigned r;
        if (quiet)
        begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 55)
        begin
            return 0;
        end
        if (r < 85)
        begin
            return $urandom_range(1, 3);
        end
        if (r < 97)
        begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 40);
    endfunction

    // Offers one text byte and waits until the block takes it.
    task automatic send_byte(input logic [7:0] b, input logic last);
        int unsigned gap;
        gap = pick_gap();
        if (gap != 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.in_byte <= b;
        in_ch.in_last <= last;
        do
        begin
            @(posedge clk);
        end
        while (!in_ch.ready);
        sent_bytes++;
    endtask

    // Sends the prepared string with the end mark on its final byte.
    task automatic send_text();
        int i;
        for (i = 0; i < text_bytes.size(); i++)
        begin
            send_byte(text_bytes[i], i == text_bytes.size() - 1);
        end
    endtask

    // Adds one byte to the end of the string being prepared.
    function automatic void add_text_byte(logic [7:0] b);
        text_bytes.insert(text_bytes.size(), b);
    endfunction

    // Appends one structurally complete character with random content.
    function automatic void add_good_char();
        int unsigned len;
        int unsigned k;
        len = $urandom_range(1, 4);
        case (len)
            1:       add_text_byte(8'($urandom_range(0, 127)));
            2:       add_text_byte(8'hC0 | 8'($urandom_range(0, 31)));
            3:       add_text_byte(8'hE0 | 8'($urandom_range(0, 15)));
            default: add_text_byte(8'hF0 | 8'($urandom_range(0, 7)));
        endcase
        for (k = 1; k < len; k++)
        begin
            add_text_byte(8'h80 | 8'($urandom_range(0, 63)));
        end
    endfunction

    // Appends something broken: a random byte, a stray continuation, a bad lead
    // or a sequence that is cut short.
    function automatic void add_bad_char();
        int unsigned len;
        int unsigned k;
        case ($urandom_range(0, 3))
            0: add_text_byte(8'($urandom_range(0, 255)));
            1: add_text_byte(8'h80 | 8'($urandom_range(0, 63)));
            2: add_text_byte(8'hF8 | 8'($urandom_range(0, 7)));
            default:
            begin
                len = $urandom_range(2, 4);
                case (len)
                    2:       add_text_byte(8'hC0 | 8'($urandom_range(0, 31)));
                    3:       add_text_byte(8'hE0 | 8'($urandom_range(0, 15)));
                    default: add_text_byte(8'hF0 | 8'($urandom_range(0, 7)));
                endcase
                for (k = $urandom_range(0, len - 2); k > 0; k--)
                begin
                    add_text_byte(8'h80 | 8'($urandom_range(0, 63)));
                end
            end
        endcase
    endfunction

    // Receiver: alternates spans of readiness with stalls of random length.
    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            int unsigned stall;
            stall = pick_gap();
            if (stall != 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
    end

    // Observes both channels at each edge and watches for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_ch.valid && in_ch.ready)
            begin
                sb.note_input(in_ch.in_byte, in_ch.in_last);
            end
            if (out_ch.valid && out_ch.ready)
            begin
                sb.check_result(out_ch.out_byte, out_ch.out_run_last, out_ch.out_text_end);
            end
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
                if (idle_cycles >= HANG_LIMIT)
                begin
                    $display("CHECKS FAILED");
                    $finish;
                end
            end
        end
    end

    // Main sequence: reset, directed strings, random strings, drain and verdict.
    initial
    begin
        int unsigned chars;
        sb            = new();
        sent_bytes    = 0;
        idle_cycles   = 0;
        quiet         = 1'b0;
        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.in_byte = 8'h00;
        in_ch.in_last = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Plain ASCII at both ends of its range.
        text_bytes = {8'h00, 8'h7F};
        send_text();
        // Complete two, three and four byte characters; the last one meets the end mark.
        text_bytes = {8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
        send_text();
        // Stray continuations and bytes that can never lead.
        text_bytes = {8'h80, 8'hBF, 8'hF8, 8'hFF};
        send_text();
        // Leads broken by a non-continuation, which is then taken as a new lead.
        text_bytes = {8'hC3, 8'h41, 8'hE2, 8'h82, 8'h41};
        send_text();
        // Three held bytes broken by a new lead that the end mark cuts off.
        text_bytes = {8'hF0, 8'h90, 8'h80, 8'hC3};
        send_text();
        // Sequence cut off by the end of the string.
        text_bytes = {8'hE2, 8'h82};
        send_text();

        // Random strings, mostly well formed, with some broken content mixed in.
        while (sent_bytes < 26 + RANDOM_BYTES)
        begin
            quiet = ($urandom_range(0, 4) == 0);
            text_bytes.delete();
            for (chars = $urandom_range(1, 8); chars > 0; chars--)
            begin
                if ($urandom_range(0, 99) < 80)
                begin
                    add_good_char();
                end
                else
                begin
                    add_bad_char();
                end
            end
            send_text();
        end
        quiet = 1'b0;
        in_ch.valid <= 1'b0;

        // Wait for the outstanding bytes, then give stray output a chance to appear.
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
